/* rtl/olist_pkg.sv */
// Shared codes, field widths and types for the ordered value list.
package olist_pkg;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned POS_W   = 5;
  localparam int unsigned CNT_W   = 5;

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 16;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_ABSENT = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd3;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } olist_state_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic                      cap;       // latch compare result
    logic                      ins;       // append at the tail cell
    logic                      del;       // close the gap after first match
    logic signed [VALUE_W-1:0] cmp_value; // value compared on capture
    logic signed [VALUE_W-1:0] wr_value;  // value written on append
  } olist_ctrl_t;

endpackage

/* rtl/olist_cell.sv */
// One list slot: stored entry, match flag, first-match chain and shift-down.
module olist_cell #(
  parameter int unsigned CW  = 5,
  parameter int unsigned IDX = 0
) (
  input  logic                                clk,
  input  olist_pkg::olist_ctrl_t              ctrl,
  input  logic [CW-1:0]                       count,
  input  logic signed [olist_pkg::VALUE_W-1:0] next_entry,
  input  logic                                seen_in,
  output logic signed [olist_pkg::VALUE_W-1:0] entry,
  output logic                                seen_out,
  output logic                                first
);

  localparam logic [CW-1:0] MY_IDX = CW'(IDX);

  logic signed [olist_pkg::VALUE_W-1:0] entry_r;
  logic                                 match_r;
  logic                                 valid;
  logic                                 tail;

  assign valid    = MY_IDX < count;
  assign tail     = MY_IDX == count;
  assign seen_out = seen_in | match_r;
  assign first    = match_r & ~seen_in;
  assign entry    = entry_r;

  always_ff @(posedge clk) begin
    if (ctrl.cap) begin
      match_r <= valid && (entry_r == ctrl.cmp_value);
    end
  end

  // Insert fills the tail; delete shifts down from the first match.
  always_ff @(posedge clk) begin
    if (ctrl.ins && tail) begin
      entry_r <= ctrl.wr_value;
    end else if (ctrl.del && seen_out) begin
      entry_r <= next_entry;
    end
  end

endmodule

/* rtl/ordered_value_list.sv */
// Top level of the ordered value list: command sequencer, cell row, result register.
// A command is captured on its transfer while the cells latch their compare result; in the
// execute state the cells update and the result register loads once the result slot is free.
// A new command is taken only after the previous one has completed.
// Reset (rst_n low, synchronous): empties the list and drops any pending result;
// stored entries keep their contents, only entries below the count ever take part in a compare.
module ordered_value_list #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [olist_pkg::IN_DATA_W-1:0]     in_tdata,  // [1:0] cmd, [33:2] value, zero pad
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [olist_pkg::OUT_DATA_W-1:0]    out_tdata  // [1:0] status, [6:2] position,
                                                         // [11:7] entry_count, zero pad
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE     = CW'(1);

  // Sequencer state and the held command
  olist_pkg::olist_state_t state_r, state_nxt;
  logic [olist_pkg::CMD_W-1:0]          cmd_r;
  logic signed [olist_pkg::VALUE_W-1:0] value_r;
  logic [CW-1:0]                        count_r, count_nxt;

  logic in_xfer;
  logic exec_go;

  // Result register
  logic                         out_valid_r;
  logic [olist_pkg::STAT_W-1:0] res_status_r, res_status;
  logic [olist_pkg::POS_W-1:0]  res_pos_r, res_pos5;
  logic [olist_pkg::CNT_W-1:0]  res_cnt_r, res_cnt5;
  logic [CW-1:0]                res_pos;

  // Cell row
  olist_pkg::olist_ctrl_t               ctrl;
  logic                                 do_ins, do_del;
  logic signed [olist_pkg::VALUE_W-1:0] ent [CAPACITY];
  logic [CAPACITY:0]                    seen;
  logic [CAPACITY-1:0]                  first;
  logic                                 hit;
  logic [CW+olist_pkg::POS_W-1:0]       pos_wide, cnt_wide;

  assign in_xfer = in_tvalid & in_tready;

  // Next state: take a command in idle, finish it once the result slot is free.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      olist_pkg::S_IDLE: begin
        if (in_tvalid) state_nxt = olist_pkg::S_EXEC;
      end
      olist_pkg::S_EXEC: begin
        if (!out_valid_r || out_tready) state_nxt = olist_pkg::S_IDLE;
      end
      default: state_nxt = olist_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_tready = 1'b0;
    exec_go   = 1'b0;
    case (state_r)
      olist_pkg::S_IDLE: in_tready = 1'b1;
      olist_pkg::S_EXEC: exec_go   = !out_valid_r || out_tready;
      default: begin
        in_tready = 1'b0;
        exec_go   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= olist_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Hold the command while it executes; the cells compare against the input value itself.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_r   <= in_tdata[olist_pkg::CMD_W-1:0];
      value_r <= in_tdata[olist_pkg::CMD_W +: olist_pkg::VALUE_W];
    end
  end

  // First match is the lowest cell with its flag set; the chain carries "seen" upward.
  assign seen[0] = 1'b0;
  assign hit     = seen[CAPACITY];

  // One-hot first-match flag to a 1-based position.
  always_comb begin
    res_pos = '0;
    for (int unsigned i = 0; i < CAPACITY; i++) begin
      res_pos = res_pos | (first[i] ? CW'(i + 1) : '0);
    end
  end

  // Decide the result and the update from the held command and the count.
  always_comb begin
    res_status = olist_pkg::ST_OK;
    count_nxt  = count_r;
    do_ins     = 1'b0;
    do_del     = 1'b0;
    pos_wide   = '0;
    case (cmd_r)
      olist_pkg::CMD_INSERT: begin
        if (count_r == CAP_CNT) begin
          res_status = olist_pkg::ST_FULL;
        end else begin
          do_ins    = 1'b1;
          count_nxt = count_r + ONE;
        end
      end
      olist_pkg::CMD_DELETE: begin
        if (count_r == '0) begin
          res_status = olist_pkg::ST_EMPTY;
        end else if (hit) begin
          do_del    = 1'b1;
          count_nxt = count_r - ONE;
        end else begin
          res_status = olist_pkg::ST_ABSENT;
        end
      end
      olist_pkg::CMD_SEARCH: begin
        if (hit) begin
          pos_wide = {{olist_pkg::POS_W{1'b0}}, res_pos};
        end else begin
          res_status = olist_pkg::ST_ABSENT;
        end
      end
      default: res_status = olist_pkg::ST_OK;
    endcase
  end

  // Mask position and count to the result field width.
  assign cnt_wide = {{olist_pkg::CNT_W{1'b0}}, count_nxt};
  assign res_pos5 = pos_wide[olist_pkg::POS_W-1:0];
  assign res_cnt5 = cnt_wide[olist_pkg::CNT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (exec_go) begin
      count_r <= count_nxt;
    end
  end

  // Broadcast to the cells: capture on the command transfer, update on completion.
  always_comb begin
    ctrl.cap       = in_xfer;
    ctrl.ins       = exec_go & do_ins;
    ctrl.del       = exec_go & do_del;
    ctrl.cmp_value = in_tdata[olist_pkg::CMD_W +: olist_pkg::VALUE_W];
    ctrl.wr_value  = value_r;
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    olist_cell #(
      .CW  (CW),
      .IDX (g)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .count      (count_r),
      .next_entry (ent[(g + 1 < CAPACITY) ? g + 1 : g]),
      .seen_in    (seen[g]),
      .entry      (ent[g]),
      .seen_out   (seen[g+1]),
      .first      (first[g])
    );
  end

  // Result register: load on completion, drop on the output transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      res_status_r <= res_status;
      res_pos_r    <= res_pos5;
      res_cnt_r    <= res_cnt5;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, res_cnt_r, res_pos_r, res_status_r};

endmodule

/* tb/sv/tb_ordered_value_list.sv */
// Self-checking stream testbench for the ordered value list, with its own list predictor.
`timescale 1ns / 100ps

module tb_ordered_value_list;
  import olist_pkg::*;

  localparam int unsigned CAP           = 16;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned SINK_HOLD_LEN = 300;
  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam int unsigned RUN_ITEMS     = 540;

  // The command field is two bits wide; the fourth code is unused and must be ignored.
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]   op;
    logic [VALUE_W-1:0] val;
  } list_cmd_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  position;
    logic [CNT_W-1:0]  entry_count;
  } outcome_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  list_cmd_t   cmd_queue[$];
  outcome_t    pending_outcomes[$];

  // Predictor state: stored values, head first, and how many are valid.
  logic [VALUE_W-1:0] held_vals[CAP];
  int unsigned        held_count = 0;

  bit          in_fire          = 1'b0;
  int unsigned src_idle_pct     = 26;
  int unsigned sink_idle_pct    = 81;
  bit          sink_hold_on     = 1'b0;
  int unsigned sink_hold_cycles = 0;
  int unsigned fail_count       = 0;
  int unsigned cycle_count      = 0;

  ordered_value_list #(
    .CAPACITY(CAP)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Apply one command to the predicted list and return the result it gives.
  function automatic outcome_t list_outcome(input logic [CMD_W-1:0] op,
                                            input logic [VALUE_W-1:0] val);
    outcome_t res;
    int       hit;
    res.status   = ST_OK;
    res.position = '0;
    hit = -1;
    for (int i = 0; i < int'(held_count); i++) begin
      if (hit < 0 && held_vals[i] == val) hit = i;
    end
    case (op)
      CMD_INSERT: begin
        if (held_count >= CAP) begin
          res.status = ST_FULL;
        end else begin
          held_vals[held_count] = val;
          held_count++;
        end
      end
      CMD_DELETE: begin
        if (held_count == 0) begin
          res.status = ST_EMPTY;
        end else if (hit < 0) begin
          res.status = ST_ABSENT;
        end else begin
          // close the gap so the order of the remaining entries holds
          for (int i = hit; i + 1 < int'(held_count); i++) held_vals[i] = held_vals[i + 1];
          held_count--;
        end
      end
      CMD_SEARCH: begin
        if (hit < 0) res.status = ST_ABSENT;
        else res.position = POS_W'(hit + 1);
      end
      default: ;
    endcase
    res.entry_count = CNT_W'(held_count);
    return res;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  task automatic queue_cmd(input logic [CMD_W-1:0] op, input logic [VALUE_W-1:0] val);
    list_cmd_t c;
    c.op  = op;
    c.val = val;
    cmd_queue.push_back(c);
  endtask

  // Random run in stretches that fill, drain or mix, so the list swings between
  // empty and full. Values come mostly from a small pool to give hits and duplicates.
  task automatic queue_random_run(input int unsigned n_items);
    logic [VALUE_W-1:0] pool[12];
    int unsigned        mode;
    int unsigned        roll;
    logic [CMD_W-1:0]   op;
    logic [VALUE_W-1:0] val;
    mode = 0;
    for (int i = 0; i < 12; i++) pool[i] = $urandom;
    pool[0] = 32'h8000_0000;
    pool[1] = 32'h7fff_ffff;
    pool[2] = 32'h0000_0000;
    pool[3] = 32'hffff_ffff;
    for (int unsigned n = 0; n < n_items; n++) begin
      if (n % 40 == 0) mode = $urandom_range(2);
      roll = $urandom_range(99);
      case (mode)
        0: op = (roll < 65) ? CMD_INSERT : (roll < 80) ? CMD_DELETE :
                (roll < 97) ? CMD_SEARCH : CMD_SPARE;
        1: op = (roll < 15) ? CMD_INSERT : (roll < 75) ? CMD_DELETE :
                (roll < 97) ? CMD_SEARCH : CMD_SPARE;
        default: op = (roll < 35) ? CMD_INSERT : (roll < 65) ? CMD_DELETE :
                      (roll < 95) ? CMD_SEARCH : CMD_SPARE;
      endcase
      val = ($urandom_range(99) < 85) ? pool[$urandom_range(11)] : $urandom;
      queue_cmd(op, val);
    end
  endtask

  // Sender: hold an offered command until its transfer, then offer the next or idle.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fire) begin
      if (cmd_queue.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        in_tdata  <= {{(IN_DATA_W - CMD_W - VALUE_W){1'b0}}, cmd_queue[0].val,
                      cmd_queue[0].op};
        in_tvalid <= 1'b1;
        void'(cmd_queue.pop_front());
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold-off so the block backs up.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (sink_hold_on && sink_hold_cycles < SINK_HOLD_LEN) begin
      out_tready       <= 1'b0;
      sink_hold_cycles <= sink_hold_cycles + 1;
    end else begin
      out_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Monitor: predict on each command transfer, check each result transfer in order.
  always @(posedge clk) begin
    outcome_t want;
    in_fire = rst_n && in_tvalid && in_tready;
    if (in_fire) pending_outcomes.push_back(list_outcome(in_tdata[1:0], in_tdata[33:2]));
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_outcomes.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual %h", $time, out_tdata);
        fail_count++;
      end else begin
        want = pending_outcomes.pop_front();
        check_field("status", want.status, out_tdata[1:0]);
        check_field("position", want.position, out_tdata[6:2]);
        check_field("entry_count", want.entry_count, out_tdata[11:7]);
        check_field("pad", 0, out_tdata[OUT_DATA_W-1:12]);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL ordered_value_list");
      $finish;
    end
  end

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // empty list: delete, search and the unused code
    queue_cmd(CMD_DELETE, 32'd5);
    queue_cmd(CMD_SEARCH, 32'd5);
    queue_cmd(CMD_SPARE, 32'hffff_ffff);
    // extremes of the value, then a duplicate to test first-match handling
    queue_cmd(CMD_INSERT, 32'h8000_0000);
    queue_cmd(CMD_INSERT, 32'h7fff_ffff);
    queue_cmd(CMD_INSERT, 32'h0000_0000);
    queue_cmd(CMD_INSERT, 32'hffff_ffff);
    queue_cmd(CMD_INSERT, 32'h7fff_ffff);
    queue_cmd(CMD_SEARCH, 32'h7fff_ffff);
    queue_cmd(CMD_DELETE, 32'h7fff_ffff);
    queue_cmd(CMD_SEARCH, 32'h7fff_ffff);
    queue_cmd(CMD_DELETE, 32'd12345);
    // fill to capacity, then insert when full
    for (int i = 0; i < 12; i++) queue_cmd(CMD_INSERT, 32'h0000_0100 + i);
    queue_cmd(CMD_INSERT, 32'h5555_aaaa);

    // sender idles often, receiver idles more
    queue_random_run(RUN_ITEMS);
    while (cmd_queue.size() != 0) @(posedge clk);

    // swap the idle rates
    @(posedge clk);
    src_idle_pct  = 81;
    sink_idle_pct = 26;
    queue_random_run(RUN_ITEMS);
    while (cmd_queue.size() != 0) @(posedge clk);

    // no idling on either side, opening with a long receiver hold-off
    @(posedge clk);
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    sink_hold_on  = 1'b1;
    queue_random_run(RUN_ITEMS);

    while (cmd_queue.size() != 0 || in_tvalid || pending_outcomes.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS ordered_value_list");
    end else begin
      $display("FAIL ordered_value_list");
    end
    $finish;
  end

endmodule
